// ----- src/gkd_pkg.sv -----
package gkd_pkg;

  localparam int unsigned IN_FRAC_BITS    = 12;
  localparam int unsigned OUT_FRAC_BITS   = 14;
  localparam int unsigned EXP_TABLE_DEPTH = 256;

  localparam int unsigned EXP_IDX_W  = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned ROM_ADDR_W = EXP_IDX_W + 1;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned RES_W  = 20;
  localparam int unsigned CUT_W  = 16;

  // |h| and h^2 in input units
  localparam int unsigned HABS_W = DIST_W;
  localparam int unsigned X_W    = 2 * DIST_W - 1;

  // exp(-x) in Q.30
  localparam int unsigned E_W = 31;

  // base-2 exponent: integer and fraction parts
  localparam int unsigned K_W     = 8;
  localparam int unsigned F_W     = 16;
  localparam int unsigned Y_W     = K_W + F_W;
  localparam int unsigned Y_SHIFT = 2 * IN_FRAC_BITS + 14;
  localparam int unsigned K_LIMIT = E_W + 1;

  localparam int unsigned CUT_SHIFT = 2 * IN_FRAC_BITS - 8;
  localparam int unsigned HM_SHIFT  = 16 - IN_FRAC_BITS;
  localparam int unsigned H2_SHIFT  = 2 * IN_FRAC_BITS - 16;
  localparam int unsigned OUT_SHIFT = 46 - OUT_FRAC_BITS;

  localparam int unsigned HM_W = HABS_W + HM_SHIFT;
  localparam int unsigned H2_W = 23;
  localparam int unsigned H4_W = 29;
  localparam int unsigned TM_W = 24;
  localparam int unsigned P_W  = 36;
  localparam int unsigned PM_W = 34;
  localparam int unsigned PROD_W = 64;

  localparam logic [E_W-1:0] LOG2E_Q30 = 31'd1549082005;
  localparam longint         LN2_Q30   = 64'sd744261118;
  localparam longint         Q30_ONE   = 64'sd1073741824;
  localparam int unsigned    Q30_BITS  = 30;

  localparam longint EXP_HALF_DEPTH = longint'(EXP_TABLE_DEPTH / 2);

  localparam logic [RES_W-1:0] RES_MAX     = 20'd524287;
  localparam logic [RES_W:0]   RES_MIN_MAG = 21'd524288;

  typedef enum logic [ACT_W-1:0] {
    ACT_VALUE,
    ACT_DERIV1,
    ACT_DERIV2,
    ACT_DERIV3,
    ACT_DERIV4,
    ACT_DERIV1_OVER_H
  } action_e;

  typedef logic [E_W-1:0] exp_val_t;
  typedef exp_val_t [EXP_TABLE_DEPTH:0] exp_rom_t;

  // unsigned long division, used only while building the table
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // 2^-(i/depth) in Q.30, from a truncated series of exp(-a)
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t        rom;
    longint          a;
    longint          term;
    longint          sum;
    longint          tprod;
    longint unsigned pmag;
    longint unsigned q;
    rom = '0;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      a    = (longint'(i) * LN2_Q30 + EXP_HALF_DEPTH) >>> EXP_IDX_W;
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (int n = 1; n <= 24; n++) begin
        // -(term * a) / (n * 2^30), truncated toward zero
        tprod = term * a;
        pmag  = (tprod < 0) ? $unsigned(-tprod) : $unsigned(tprod);
        q     = div_u64(pmag >> Q30_BITS, longint'(n));
        if (tprod < 0) begin
          term = $signed(q);
        end else begin
          term = -$signed(q);
        end
        sum = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > Q30_ONE) begin
        sum = Q30_ONE;
      end
      rom[i] = sum[E_W-1:0];
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

// ----- src/gkd_exp.sv -----
module gkd_exp (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [gkd_pkg::X_W-1:0]    x_i,
  output logic [gkd_pkg::E_W-1:0]    e_o
);

  localparam int unsigned YP_W = 2 * gkd_pkg::X_W + 1;
  localparam int unsigned P_W  = gkd_pkg::F_W + gkd_pkg::EXP_IDX_W;
  localparam int unsigned DR_W = gkd_pkg::E_W + gkd_pkg::F_W + 1;
  localparam int unsigned SH_W = gkd_pkg::E_W + gkd_pkg::K_LIMIT;

  // stage 1: exponent in base 2
  logic [YP_W-1:0]           yprod;
  logic [gkd_pkg::Y_W-1:0]   y;
  logic [gkd_pkg::K_W-1:0]   k1_q;
  logic [gkd_pkg::F_W-1:0]   f1_q;

  assign yprod = YP_W'(x_i) * YP_W'(gkd_pkg::LOG2E_Q30)
               + (YP_W'(1) << (gkd_pkg::Y_SHIFT - 1));
  assign y     = yprod[gkd_pkg::Y_SHIFT +: gkd_pkg::Y_W];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k1_q <= y[gkd_pkg::Y_W-1:gkd_pkg::F_W];
      f1_q <= y[gkd_pkg::F_W-1:0];
    end
  end

  // stage 2: table lookup
  logic [P_W-1:0]                   p;
  logic [gkd_pkg::EXP_IDX_W-1:0]    idx;
  logic [gkd_pkg::ROM_ADDR_W-1:0]   addr0;
  logic [gkd_pkg::ROM_ADDR_W-1:0]   addr1;
  logic [gkd_pkg::E_W-1:0]          t0;
  logic [gkd_pkg::E_W-1:0]          t1;
  logic [gkd_pkg::E_W-1:0]          t0_q;
  logic [gkd_pkg::E_W-1:0]          d_q;
  logic [gkd_pkg::F_W-1:0]          r_q;
  logic [gkd_pkg::K_W-1:0]          k2_q;

  assign p     = {f1_q, gkd_pkg::EXP_IDX_W'(0)};
  assign idx   = p[gkd_pkg::F_W +: gkd_pkg::EXP_IDX_W];
  assign addr0 = {1'b0, idx};
  assign addr1 = addr0 + gkd_pkg::ROM_ADDR_W'(1);
  assign t0    = gkd_pkg::EXP_ROM[addr0];
  assign t1    = gkd_pkg::EXP_ROM[addr1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t0_q <= t0;
      d_q  <= t0 - t1;
      r_q  <= p[gkd_pkg::F_W-1:0];
      k2_q <= k1_q;
    end
  end

  // stage 3: linear interpolation
  logic [DR_W-1:0]          dr;
  logic [gkd_pkg::E_W-1:0]  m_q;
  logic [gkd_pkg::K_W-1:0]  k3_q;

  assign dr = DR_W'(d_q) * DR_W'(r_q) + DR_W'(32768);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q  <= t0_q - dr[gkd_pkg::F_W +: gkd_pkg::E_W];
      k3_q <= k2_q;
    end
  end

  // stage 4: rounded shift by the integer part
  logic [SH_W-1:0]          sh;
  logic [gkd_pkg::E_W-1:0]  e_d;
  logic [gkd_pkg::E_W-1:0]  e_q;

  always_comb begin
    sh = {m_q, gkd_pkg::K_LIMIT'(0)} >> k3_q;
    if (k3_q >= gkd_pkg::K_W'(gkd_pkg::K_LIMIT)) begin
      e_d = '0;
    end else begin
      e_d = sh[SH_W-1:gkd_pkg::K_LIMIT] + gkd_pkg::E_W'(sh[gkd_pkg::K_LIMIT-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q <= e_d;
    end
  end

  assign e_o = e_q;

endmodule

// ----- src/gaussian_kernel_derivatives_core.sv -----
// Gaussian kernel exp(-h^2) and its derivatives. Each input word carries a
// signed Q4.12 distance and an action code (0 value, 1 to 4 derivative of
// that degree, 5 first derivative over h); each word yields one result word,
// signed Q6.14 with saturation, and cut_off set with a zero result when h^2
// exceeds cutoff_sq (unsigned Q8.8, reset 64.0). Codes 6 and 7 give zero.
// A new word is taken every cycle unless the output word waits. The whole
// pipeline advances together and holds while the output word waits, so
// throughput is one word per cycle whenever the sink takes words every
// cycle. The user writes cutoff_sq through its own port only while no word
// is in flight; the block itself does not enforce this.
module gaussian_kernel_derivatives_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gkd_pkg::CUT_W-1:0]     cutoff_sq_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gkd_pkg::ACT_W-1:0]     action_i,
  input  logic signed [gkd_pkg::DIST_W-1:0] distance_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [gkd_pkg::RES_W-1:0]  result_o,
  output logic                          cut_off_o
);

  localparam int unsigned XC_W = gkd_pkg::X_W + 1;
  localparam int unsigned H2S_W = gkd_pkg::X_W + 1;
  localparam int unsigned H4P_W = 2 * gkd_pkg::H2_W + 1;
  localparam int unsigned P3_W  = gkd_pkg::HM_W + gkd_pkg::TM_W + 4;
  localparam int unsigned MAG_W = gkd_pkg::PROD_W - gkd_pkg::OUT_SHIFT;

  logic en;
  logic out_valid_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // cutoff register
  logic [gkd_pkg::CUT_W-1:0] cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= gkd_pkg::CUT_W'(16384);
    end else if (cfg_valid_i) begin
      cutoff_q <= cutoff_sq_i;
    end
  end

  // stage 1: magnitude and square
  logic [gkd_pkg::HABS_W-1:0] habs;
  logic                       v1_q;
  gkd_pkg::action_e           act1_q;
  logic                       hneg1_q;
  logic [gkd_pkg::HABS_W-1:0] habs1_q;
  logic [gkd_pkg::X_W-1:0]    x1_q;

  assign habs = distance_i[gkd_pkg::DIST_W-1] ? (~distance_i + 1'b1) : distance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act1_q  <= gkd_pkg::action_e'(action_i);
      hneg1_q <= distance_i[gkd_pkg::DIST_W-1];
      habs1_q <= habs;
      x1_q    <= gkd_pkg::X_W'(habs) * gkd_pkg::X_W'(habs);
    end
  end

  // exp(-h^2), four stages behind stage 1
  logic [gkd_pkg::E_W-1:0] e5;

  gkd_exp u_exp (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (x1_q),
    .e_o   (e5)
  );

  // stage 2: h, h^2 in Q.16, cutoff check
  logic [H2S_W-1:0]         h2sum;
  logic                     cut;
  logic                     bad_act;
  logic                     v2_q;
  gkd_pkg::action_e         act2_q;
  logic                     hneg2_q;
  logic [gkd_pkg::HM_W-1:0] hm2_q;
  logic [gkd_pkg::H2_W-1:0] h22_q;
  logic                     zero2_q;
  logic                     cut2_q;

  assign h2sum   = H2S_W'(x1_q) + (H2S_W'(1) << (gkd_pkg::H2_SHIFT - 1));
  assign cut     = XC_W'(x1_q) > (XC_W'(cutoff_q) << gkd_pkg::CUT_SHIFT);
  assign bad_act = act1_q > gkd_pkg::ACT_DERIV1_OVER_H;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act2_q  <= act1_q;
      hneg2_q <= hneg1_q;
      hm2_q   <= {habs1_q, gkd_pkg::HM_SHIFT'(0)};
      h22_q   <= gkd_pkg::H2_W'(h2sum >> gkd_pkg::H2_SHIFT);
      zero2_q <= bad_act || cut;
      cut2_q  <= !bad_act && cut;
    end
  end

  // stage 3: h^4 and 3 - 2h^2
  logic [H4P_W-1:0]                 h4p;
  logic signed [gkd_pkg::TM_W:0]    t3;
  logic                             v3_q;
  gkd_pkg::action_e                 act3_q;
  logic                             hneg3_q;
  logic [gkd_pkg::HM_W-1:0]         hm3_q;
  logic [gkd_pkg::H2_W-1:0]         h23_q;
  logic [gkd_pkg::H4_W-1:0]         h43_q;
  logic [gkd_pkg::TM_W-1:0]         tm3_q;
  logic                             tneg3_q;
  logic                             zero3_q;
  logic                             cut3_q;

  assign h4p = H4P_W'(h22_q) * H4P_W'(h22_q) + H4P_W'(32768);
  assign t3  = (gkd_pkg::TM_W + 1)'(196608) - {1'b0, h22_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      act3_q  <= act2_q;
      hneg3_q <= hneg2_q;
      hm3_q   <= hm2_q;
      h23_q   <= h22_q;
      h43_q   <= h4p[16 +: gkd_pkg::H4_W];
      tm3_q   <= t3[gkd_pkg::TM_W] ? gkd_pkg::TM_W'(-t3) : gkd_pkg::TM_W'(t3);
      tneg3_q <= t3[gkd_pkg::TM_W];
      zero3_q <= zero2_q;
      cut3_q  <= cut2_q;
    end
  end

  // stage 4: polynomial factor in Q.16
  logic [P3_W-1:0]                p3;
  logic signed [gkd_pkg::P_W-1:0] h2s;
  logic signed [gkd_pkg::P_W-1:0] h4s;
  logic signed [gkd_pkg::P_W-1:0] poly4;
  logic signed [gkd_pkg::P_W-1:0] p_d;
  logic                           pn_d;
  logic                           v4_q;
  logic signed [gkd_pkg::P_W-1:0] p4_q;
  logic                           pn4_q;
  logic                           zero4_q;
  logic                           cut4_q;

  assign p3    = (P3_W'(hm3_q) * P3_W'(tm3_q) << 2) + P3_W'(32768);
  assign h2s   = $signed(gkd_pkg::P_W'(h23_q));
  assign h4s   = $signed(gkd_pkg::P_W'(h43_q));
  assign poly4 = gkd_pkg::P_W'(196608) - h2s * gkd_pkg::P_W'(12) + (h4s <<< 2);

  always_comb begin
    p_d  = '0;
    pn_d = 1'b0;
    case (act3_q)
      gkd_pkg::ACT_VALUE: begin
        p_d = gkd_pkg::P_W'(65536);
      end
      gkd_pkg::ACT_DERIV1: begin
        p_d  = $signed(gkd_pkg::P_W'({hm3_q, 1'b0}));
        pn_d = !hneg3_q && (hm3_q != '0);
      end
      gkd_pkg::ACT_DERIV2: begin
        p_d = (h2s <<< 2) - gkd_pkg::P_W'(131072);
      end
      gkd_pkg::ACT_DERIV3: begin
        p_d  = $signed(gkd_pkg::P_W'(p3 >> 16));
        pn_d = hneg3_q != tneg3_q;
      end
      gkd_pkg::ACT_DERIV4: begin
        p_d = poly4 <<< 2;
      end
      gkd_pkg::ACT_DERIV1_OVER_H: begin
        p_d = -gkd_pkg::P_W'(131072);
      end
      default: begin
        p_d  = '0;
        pn_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_q    <= p_d;
      pn4_q   <= pn_d;
      zero4_q <= zero3_q;
      cut4_q  <= cut3_q;
    end
  end

  // stage 5: sign and magnitude of the factor
  logic [gkd_pkg::P_W-1:0]  pabs;
  logic                     v5_q;
  logic [gkd_pkg::PM_W-1:0] pm5_q;
  logic                     pneg5_q;
  logic                     zero5_q;
  logic                     cut5_q;

  assign pabs = p4_q[gkd_pkg::P_W-1] ? gkd_pkg::P_W'(-p4_q) : gkd_pkg::P_W'(p4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pm5_q   <= pabs[gkd_pkg::PM_W-1:0];
      pneg5_q <= pn4_q ^ p4_q[gkd_pkg::P_W-1];
      zero5_q <= zero4_q;
      cut5_q  <= cut4_q;
    end
  end

  // stage 6: factor times exp
  logic                       v6_q;
  logic [gkd_pkg::PROD_W-1:0] prod6_q;
  logic                       pneg6_q;
  logic                       zero6_q;
  logic                       cut6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod6_q <= gkd_pkg::PROD_W'(pm5_q) * gkd_pkg::PROD_W'(e5);
      pneg6_q <= pneg5_q;
      zero6_q <= zero5_q;
      cut6_q  <= cut5_q;
    end
  end

  // stage 7: round, saturate, output register
  logic [gkd_pkg::PROD_W-1:0] rsum;
  logic [MAG_W-1:0]           mag;
  logic                       rneg;
  logic [gkd_pkg::RES_W-1:0]  res_d;
  logic [gkd_pkg::RES_W-1:0]  result_q;
  logic                       cut_off_q;

  assign rsum = prod6_q + (gkd_pkg::PROD_W'(1) << (gkd_pkg::OUT_SHIFT - 1));
  assign mag  = rsum[gkd_pkg::PROD_W-1:gkd_pkg::OUT_SHIFT];
  assign rneg = pneg6_q && (mag != '0);

  always_comb begin
    if (zero6_q) begin
      res_d = '0;
    end else if (rneg) begin
      if (mag > MAG_W'(gkd_pkg::RES_MIN_MAG)) begin
        res_d = gkd_pkg::RES_W'(-gkd_pkg::RES_MIN_MAG);
      end else begin
        res_d = gkd_pkg::RES_W'(-mag);
      end
    end else if (mag > MAG_W'(gkd_pkg::RES_MAX)) begin
      res_d = gkd_pkg::RES_MAX;
    end else begin
      res_d = gkd_pkg::RES_W'(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_q  <= res_d;
      cut_off_q <= cut6_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = $signed(result_q);
  assign cut_off_o   = cut_off_q;

endmodule

// ----- bench/gkd_result_checker.sv -----
`timescale 1ns / 1ps

module gkd_result_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_o,
  input  logic [gkd_pkg::CUT_W-1:0]            cutoff_sq_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_o,
  input  logic [gkd_pkg::ACT_W-1:0]            action_i,
  input  logic signed [gkd_pkg::DIST_W-1:0]    distance_i,
  input  logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  logic signed [gkd_pkg::RES_W-1:0]     result_o,
  input  logic                                 cut_off_o,
  output int                                   err_count_o,
  output int                                   pending_o
);
  import gkd_pkg::*;

  localparam logic [CUT_W-1:0] RESET_CUTOFF = 16'd16384;
  localparam longint           QONE         = 64'sd65536;
  localparam longint           Q30          = 64'sd1073741824;
  localparam longint           LN2_FIX      = 64'sd744261118;
  localparam longint unsigned  LOG2E_FIX    = 64'd1549082005;
  localparam longint unsigned  PROD_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned  MAG_POS_MAX  = 64'd524287;
  localparam longint unsigned  MAG_NEG_MAX  = 64'd524288;

  typedef struct packed {
    logic signed [RES_W-1:0] result;
    logic                    cut_off;
  } kernel_word_t;

  longint unsigned exp_frac_tab [0:EXP_TABLE_DEPTH];
  kernel_word_t    expected_words [$];
  logic [CUT_W-1:0] cutoff_now;
  int              mismatch_count = 0;

  // 2^-(i/depth) in Q.30 from a truncated series of exp(-a)
  initial begin
    longint a;
    longint term;
    longint sum;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      a    = (longint'(i) * LN2_FIX + longint'(EXP_TABLE_DEPTH / 2)) /
             longint'(EXP_TABLE_DEPTH);
      term = Q30;
      sum  = Q30;
      for (int n = 1; n <= 24; n++) begin
        term = -(term * a) / (longint'(n) * Q30);
        sum  = sum + term;
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > Q30) begin
        sum = Q30;
      end
      exp_frac_tab[i] = sum;
    end
  end

  function automatic kernel_word_t predict_kernel_word(logic [ACT_W-1:0] act,
                                                       logic [DIST_W-1:0] dval,
                                                       logic [CUT_W-1:0] cut);
    kernel_word_t    w;
    longint unsigned hraw, x, hm, h2, h4, e, pm, prod, mag, tm;
    longint unsigned y, k, f, p, idx, r, t0, t1, m;
    longint          pf, t;
    logic            hneg, pneg;
    w.result  = '0;
    w.cut_off = 1'b0;
    pneg      = 1'b0;
    hneg      = dval[DIST_W-1];
    hraw      = hneg ? (64'd65536 - {48'd0, dval}) : {48'd0, dval};
    x         = hraw * hraw;
    if (act > ACT_DERIV1_OVER_H) begin
      return w;
    end
    if (x > ({48'd0, cut} << CUT_SHIFT)) begin
      w.cut_off = 1'b1;
      return w;
    end
    hm = hraw << HM_SHIFT;
    h2 = (x + (64'd1 << (H2_SHIFT - 1))) >> H2_SHIFT;
    h4 = (h2 * h2 + 64'd32768) >> 16;
    // exp(-x) via base-2 range reduction
    y   = (x * LOG2E_FIX + (64'd1 << (Y_SHIFT - 1))) >> Y_SHIFT;
    k   = y >> 16;
    f   = y & 64'hFFFF;
    p   = f * EXP_TABLE_DEPTH;
    idx = (p >> 16) % EXP_TABLE_DEPTH;
    r   = p & 64'hFFFF;
    t0  = exp_frac_tab[idx];
    t1  = exp_frac_tab[idx + 1];
    m   = t0 - (((t0 - t1) * r + 64'd32768) >> 16);
    if (k == 0) begin
      e = m;
    end else if (k >= 63) begin
      e = 0;
    end else begin
      e = (m + (64'd1 << (k - 1))) >> k;
    end
    case (act)
      ACT_VALUE: begin
        pf = QONE;
      end
      ACT_DERIV1: begin
        pf   = 2 * $signed(hm);
        pneg = !hneg && (hm != 0);
      end
      ACT_DERIV2: begin
        pf = 4 * $signed(h2) - 2 * QONE;
      end
      ACT_DERIV3: begin
        t    = 3 * QONE - 2 * $signed(h2);
        tm   = (t < 0) ? -t : t;
        pf   = $signed((4 * hm * tm + 64'd32768) >> 16);
        pneg = hneg != (t < 0);
      end
      ACT_DERIV4: begin
        pf = 4 * (3 * QONE - 12 * $signed(h2) + 4 * $signed(h4));
      end
      default: begin
        pf = -2 * QONE;
      end
    endcase
    if (pf < 0) begin
      pf   = -pf;
      pneg = !pneg;
    end
    pm = pf;
    if (e != 0 && pm > PROD_LIMIT / e) begin
      prod = PROD_LIMIT;
    end else begin
      prod = pm * e;
    end
    mag = (prod + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    if (pneg && mag != 0) begin
      if (mag > MAG_NEG_MAX) begin
        mag = MAG_NEG_MAX;
      end
      mag = 64'd0 - mag;
    end else if (mag > MAG_POS_MAX) begin
      mag = MAG_POS_MAX;
    end
    w.result = mag[RES_W-1:0];
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    kernel_word_t got;
    kernel_word_t want;
    if (!rst_ni) begin
      cutoff_now = RESET_CUTOFF;
      expected_words.delete();
      pending_o   <= 0;
      err_count_o <= mismatch_count;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cutoff_now = cutoff_sq_i;
      end
      if (out_valid_o && out_ready_i) begin
        got.result  = result_o;
        got.cut_off = cut_off_o;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got result %0d cut_off %0b",
                   $time, got.result, got.cut_off);
          mismatch_count++;
        end else begin
          want = expected_words.pop_front();
          if (got.result !== want.result) begin
            $display("%0t: result mismatch, expected %0d, got %0d",
                     $time, want.result, got.result);
            mismatch_count++;
          end
          if (got.cut_off !== want.cut_off) begin
            $display("%0t: cut_off mismatch, expected %0b, got %0b",
                     $time, want.cut_off, got.cut_off);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_words.push_back(predict_kernel_word(action_i, distance_i, cutoff_now));
      end
      pending_o   <= expected_words.size();
      err_count_o <= mismatch_count;
    end
  end

endmodule

// ----- bench/gaussian_kernel_derivatives_core_test.sv -----
`timescale 1ns / 1ps

module gaussian_kernel_derivatives_core_test;
  import gkd_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CUT_W-1:0]         cutoff_sq_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [ACT_W-1:0]         action_i;
  logic signed [DIST_W-1:0] distance_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [RES_W-1:0]  result_o;
  logic                     cut_off_o;

  int   err_count;
  int   pending;
  bit   no_idle;
  int   sink_hold;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  gaussian_kernel_derivatives_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cutoff_sq_i (cutoff_sq_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .distance_i  (distance_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o),
    .cut_off_o   (cut_off_o)
  );

  gkd_result_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cutoff_sq_i (cutoff_sq_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .distance_i  (distance_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result_o),
    .cut_off_o   (cut_off_o),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) begin
      return 0;
    end
    if (r < 65) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic push_word(input logic [ACT_W-1:0] act, input logic [DIST_W-1:0] dval);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    distance_i <= dval;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_words();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_cutoff(input logic [CUT_W-1:0] c);
    drain_words();
    cfg_valid_i <= 1'b1;
    cutoff_sq_i <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sink stalls
  initial begin
    out_ready_i = 1'b0;
    sink_hold   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        out_ready_i <= 1'b0;
        sink_hold--;
      end else begin
        out_ready_i <= 1'b1;
        sink_hold = pick_gap();
      end
    end
  end

  initial begin
    logic [CUT_W-1:0]  cut_plan [0:5];
    logic [CUT_W-1:0]  c;
    logic [DIST_W-1:0] d;
    logic [ACT_W-1:0]  act;
    int                kind;
    int                hb;
    int                a;
    cut_plan    = '{16'd0, 16'd65535, 16'd256, 16'd1024, 16'd16384, 16'd1};
    in_valid_i  = 1'b0;
    action_i    = '0;
    distance_i  = '0;
    cfg_valid_i = 1'b0;
    cutoff_sq_i = '0;
    no_idle     = 1'b0;
    rst_ni      = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < 8; i++) begin
      push_word(3'(i), 16'd4096);
    end
    for (int i = 0; i <= ACT_DERIV1_OVER_H; i++) begin
      push_word(3'(i), 16'hF000);
    end
    push_word(ACT_DERIV1, 16'd0);
    push_word(ACT_DERIV3, 16'd0);
    push_word(ACT_DERIV1_OVER_H, 16'd0);
    push_word(ACT_DERIV4, 16'h7FFF);
    push_word(ACT_VALUE, 16'h8000);
    push_word(ACT_DERIV2, 16'd1);
    push_word(ACT_DERIV3, 16'hFFFF);
    // near the zero of 3 - 2h^2
    push_word(ACT_DERIV3, 16'd5017);

    for (int ph = 0; ph < 8; ph++) begin
      c = (ph < 6) ? cut_plan[ph] : 16'($urandom);
      no_idle = ($urandom_range(0, 3) == 0);
      write_cutoff(c);
      if (ph == 0) begin
        push_word(ACT_VALUE, 16'd0);
        push_word(ACT_VALUE, 16'd1);
      end
      repeat (220) begin
        a   = $urandom_range(0, 19);
        act = (a < 18) ? 3'(a % 6) : ((a == 18) ? ACT_SPARE_LO : ACT_SPARE_HI);
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          d = 16'($urandom);
        end else if (kind < 7) begin
          hb = $urandom_range(0, 8191);
          d  = $urandom_range(0, 1) ? 16'(-hb) : 16'(hb);
        end else if (kind < 9) begin
          // around the cutoff boundary
          hb = $rtoi($sqrt(real'(c)) * 256.0) + int'($urandom_range(0, 4)) - 2;
          if (hb < 0) begin
            hb = 0;
          end
          if (hb > 32767) begin
            hb = 32767;
          end
          d = $urandom_range(0, 1) ? 16'(-hb) : 16'(hb);
        end else begin
          case ($urandom_range(0, 4))
            0: d = 16'h0000;
            1: d = 16'h0001;
            2: d = 16'hFFFF;
            3: d = 16'h7FFF;
            default: d = 16'h8000;
          endcase
        end
        push_word(act, d);
      end
    end

    drain_words();
    repeat (16) @(negedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
src/gkd_pkg.sv
src/gkd_exp.sv
src/gaussian_kernel_derivatives_core.sv
bench/gkd_result_checker.sv
bench/gaussian_kernel_derivatives_core_test.sv
